// File: rtl/skyra_pkg.sv
// Shared constants for the skyline rectangle allocator.
package skyra_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int HEIGHT_W        = 13;
    localparam int MAX_SHEET_H     = 4096;
    localparam int SW_W            = 9;
    localparam int SH_W            = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int IDX_W           = 16;
    localparam int PX_W            = 9;
    localparam int PY_W            = 12;
    localparam int S_DATA_W        = 32;
    localparam int M_DATA_W        = 40;

    localparam logic CFG_SHEET_WIDTH  = 1'b0;
    localparam logic CFG_SHEET_HEIGHT = 1'b1;

    localparam logic [IDX_W-1:0] SHEET_CNT_MAX = 16'hFFFF;

endpackage

// File: rtl/skyline_rect_allocator.sv
// Skyline rectangle allocator: top level with sheet registers, sequencer and column memory.
//
// Usage: each word on the s_ channel is one rectangle request; the block answers
// with exactly one word on the m_ channel holding the placement. Requests are taken
// one at a time; s_tready is high only while the sequencer is idle. A finished
// result sits in an output register, so the next request is taken while it waits.
// A request too large for the sheet, or of zero width on an open sheet, needs no
// scan. A placement scan reads one column at a time through the single read port
// of the column memory, trying each start column at which a window of the request
// width fits the sheet, and then raises the chosen columns.
// Opening a sheet sweeps all MAX_COLUMNS entries of the memory, one per cycle.
// Reset clears the sheet counter and sets both sheet registers to 256; the
// column memory is not cleared, since the first request that fits opens a sheet.
// When the receiver stalls, the result is held and the sequencer waits at its
// end until the output register frees. The user must write the sheet registers through
// cfg_wr_en, cfg_index and cfg_data only while the block is idle; it does not enforce this.
module skyline_rect_allocator #(
    parameter int MAX_COLUMNS = skyra_pkg::MAX_COLUMNS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [skyra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [12:0] rect_width, [25:13] rect_height
    input  logic [skyra_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] ok, [1] new_sheet, [17:2] sheet_index, [26:18] pos_x, [38:27] pos_y
    output logic [skyra_pkg::M_DATA_W-1:0]   m_tdata
);
    import skyra_pkg::*;

    localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    logic [SW_W-1:0]     sheet_width_reg;
    logic [SH_W-1:0]     sheet_height_reg;
    logic [HEIGHT_W-1:0] w_raw;
    logic [CNT_W-1:0]    eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
    logic [HEIGHT_W-1:0] mem_wr_data, mem_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sheet_width_reg  <= SW_W'(256);
            sheet_height_reg <= SH_W'(256);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SHEET_WIDTH:  sheet_width_reg  <= cfg_data[SW_W-1:0];
                CFG_SHEET_HEIGHT: sheet_height_reg <= cfg_data[SH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the sheet size to the usable range
    assign w_raw = HEIGHT_W'(sheet_width_reg);
    always_comb begin
        if (w_raw == '0) begin
            eff_w = CNT_W'(1);
        end else if (w_raw > HEIGHT_W'(MAX_COLUMNS)) begin
            eff_w = CNT_W'(MAX_COLUMNS);
        end else begin
            eff_w = w_raw[CNT_W-1:0];
        end
        if (sheet_height_reg == '0) begin
            eff_h = HEIGHT_W'(1);
        end else if (sheet_height_reg > HEIGHT_W'(MAX_SHEET_H)) begin
            eff_h = HEIGHT_W'(MAX_SHEET_H);
        end else begin
            eff_h = sheet_height_reg;
        end
    end

    skyra_ctrl #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .AW(AW),
        .CNT_W(CNT_W)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .eff_w(eff_w),
        .eff_h(eff_h),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .mem_wr_en(mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data)
    );

    skyra_colmem #(
        .DEPTH(MAX_COLUMNS),
        .AW(AW)
    ) u_colmem (
        .aclk(aclk),
        .wr_en(mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

endmodule

// File: rtl/skyra_colmem.sv
// Column height memory: one write port, one registered read port.
module skyra_colmem #(
    parameter int DEPTH = skyra_pkg::MAX_COLUMNS_DEF,
    parameter int AW    = 1
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [skyra_pkg::HEIGHT_W-1:0] wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [skyra_pkg::HEIGHT_W-1:0] rd_data
);
    import skyra_pkg::*;

    logic [HEIGHT_W-1:0] mem [DEPTH];
    logic [HEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/skyra_ctrl.sv
// Placement sequencer: window scan, column update, sheet clear and result register.
module skyra_ctrl #(
    parameter int MAX_COLUMNS = skyra_pkg::MAX_COLUMNS_DEF,
    parameter int AW          = 1,
    parameter int CNT_W       = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [CNT_W-1:0]                 eff_w,
    input  logic [skyra_pkg::HEIGHT_W-1:0]   eff_h,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [skyra_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [skyra_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                             mem_wr_en,
    output logic [AW-1:0]                    mem_wr_addr,
    output logic [skyra_pkg::HEIGHT_W-1:0]   mem_wr_data,
    output logic [AW-1:0]                    mem_rd_addr,
    input  logic [skyra_pkg::HEIGHT_W-1:0]   mem_rd_data
);
    import skyra_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_EV, ST_FIN, ST_WR, ST_CLR, ST_DONE
    } state_t;

    state_t              state_reg;
    logic [HEIGHT_W-1:0] rw_reg, rh_reg, top_reg, best_reg;
    logic [CNT_W-1:0]    s_reg, k_reg, at_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    count_reg;
    logic                ok_reg, new_reg;
    logic [PX_W-1:0]     px_reg;
    logic [PY_W-1:0]     py_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [HEIGHT_W-1:0] in_rw, in_rh, w_ext, top_new, place_h;
    logic [CNT_W-1:0]    rw_c, sum_addr;
    logic [CNT_W:0]      next_end;
    logic [HEIGHT_W:0]   fit_sum;
    logic [IDX_W-1:0]    idx_out;

    assign in_rw    = s_tdata[HEIGHT_W-1:0];
    assign in_rh    = s_tdata[2*HEIGHT_W-1:HEIGHT_W];
    assign w_ext    = HEIGHT_W'(eff_w);
    assign rw_c     = rw_reg[CNT_W-1:0];
    assign sum_addr = s_reg + k_reg;
    assign top_new  = (mem_rd_data > top_reg) ? mem_rd_data : top_reg;
    assign next_end = {1'b0, s_reg} + {1'b0, rw_c} + (CNT_W+1)'(1);
    assign fit_sum  = {1'b0, best_reg} + {1'b0, rh_reg};
    assign place_h  = best_reg + rh_reg;
    assign idx_out  = ok_reg ? (count_reg - IDX_W'(1)) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign mem_rd_addr = sum_addr[AW-1:0];

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = k_reg[AW-1:0];
        mem_wr_data = '0;
        case (state_reg)
            ST_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sum_addr[AW-1:0];
                mem_wr_data = place_h;
            end
            ST_CLR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = (k_reg < rw_c) ? rh_reg : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        rw_reg    <= in_rw;
                        rh_reg    <= in_rh;
                        s_reg     <= '0;
                        k_reg     <= '0;
                        at_reg    <= '0;
                        top_reg   <= '0;
                        best_reg  <= eff_h;
                        found_reg <= 1'b0;
                        ok_reg    <= 1'b1;
                        new_reg   <= 1'b0;
                        px_reg    <= '0;
                        py_reg    <= '0;
                        if (in_rw > w_ext || in_rh > eff_h) begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_DONE;
                        end else if (count_reg == '0) begin
                            state_reg <= ST_CLR;
                        end else if (in_rw == '0) begin
                            // empty window fits at every start, last one wins
                            px_reg    <= PX_W'(eff_w);
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_EV;
                end
                ST_EV: begin
                    if (mem_rd_data >= best_reg || k_reg == rw_c - CNT_W'(1)) begin
                        if (mem_rd_data < best_reg) begin
                            at_reg    <= s_reg;
                            best_reg  <= top_new;
                            found_reg <= 1'b1;
                        end
                        // advance to the next start column, or finish when none is left
                        k_reg   <= '0;
                        top_reg <= '0;
                        if (next_end > {1'b0, eff_w}) begin
                            state_reg <= ST_FIN;
                        end else begin
                            s_reg     <= s_reg + CNT_W'(1);
                            state_reg <= ST_RD;
                        end
                    end else begin
                        top_reg   <= top_new;
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_FIN: begin
                    k_reg <= '0;
                    s_reg <= at_reg;
                    if (found_reg && fit_sum <= {1'b0, eff_h}) begin
                        px_reg    <= PX_W'(at_reg);
                        py_reg    <= PY_W'(best_reg);
                        state_reg <= ST_WR;
                    end else begin
                        state_reg <= ST_CLR;
                    end
                end
                ST_WR: begin
                    k_reg <= k_reg + CNT_W'(1);
                    if (k_reg == rw_c - CNT_W'(1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_CLR: begin
                    k_reg <= k_reg + CNT_W'(1);
                    if (k_reg == CNT_W'(MAX_COLUMNS - 1)) begin
                        new_reg <= 1'b1;
                        px_reg  <= (rw_reg == '0) ? PX_W'(eff_w) : '0;
                        py_reg  <= '0;
                        if (count_reg != SHEET_CNT_MAX) begin
                            count_reg <= count_reg + IDX_W'(1);
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, py_reg, px_reg, idx_out, new_reg, ok_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: dv/skyline_rect_allocator_tb.sv
// Self-checking testbench for the skyline rectangle allocator.
`timescale 1ns / 100ps

module skyline_rect_allocator_tb;
    import skyra_pkg::*;

    localparam int  NCOL        = MAX_COLUMNS_DEF;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  CFG_W_IDX   = int'(CFG_SHEET_WIDTH);
    localparam int  CFG_H_IDX   = int'(CFG_SHEET_HEIGHT);

    typedef struct packed {
        logic [PY_W-1:0]  pos_y;
        logic [PX_W-1:0]  pos_x;
        logic [IDX_W-1:0] sheet_index;
        logic             new_sheet;
        logic             ok;
    } placement_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // predictor state
    int unsigned pred_width  = 256;
    int unsigned pred_height = 256;
    int unsigned pred_cols[NCOL];
    int unsigned pred_sheets = 0;
    placement_t  placements_due[$];

    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;

    skyline_rect_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [12:0] rect_width, [25:13] rect_height
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [0] ok, [1] new_sheet, [17:2] sheet_index, [26:18] pos_x,
                               // [38:27] pos_y
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit fit_rect(int unsigned w, int unsigned h, int unsigned rw,
                                    int unsigned rh, output int unsigned px,
                                    output int unsigned py);
        int unsigned best;
        int unsigned at;
        int unsigned top;
        int unsigned c;
        bit          found;
        bit          good;
        best  = h;
        at    = 0;
        found = 1'b0;
        px    = 0;
        py    = 0;
        for (int unsigned s = 0; s + rw <= w; s++) begin
            top  = 0;
            good = 1'b1;
            for (int unsigned k = 0; k < rw; k++) begin
                c = pred_cols[(s + k) % NCOL];
                if (c >= best) begin
                    good = 1'b0;
                    break;
                end
                if (c > top) top = c;
            end
            if (good) begin
                at    = s;
                best  = top;
                found = 1'b1;
            end
        end
        if (!found || best + rh > h) return 1'b0;
        for (int unsigned k = 0; k < rw; k++) pred_cols[(at + k) % NCOL] = best + rh;
        px = at;
        py = best;
        return 1'b1;
    endfunction

    function automatic placement_t place_rect(int unsigned rw, int unsigned rh);
        placement_t  p;
        int unsigned w;
        int unsigned h;
        int unsigned px;
        int unsigned py;
        bit          opened;
        p      = '0;
        w      = clamp(pred_width, NCOL);
        h      = clamp(pred_height, MAX_SHEET_H);
        opened = 1'b0;
        if (rw > w || rh > h) return p;
        if (pred_sheets == 0 || !fit_rect(w, h, rw, rh, px, py)) begin
            foreach (pred_cols[i]) pred_cols[i] = 0;
            if (pred_sheets < 32'hFFFF) pred_sheets++;
            opened = 1'b1;
            void'(fit_rect(w, h, rw, rh, px, py));
        end
        p.ok          = 1'b1;
        p.new_sheet   = opened;
        p.sheet_index = IDX_W'(pred_sheets - 1);
        p.pos_x       = PX_W'(px);
        p.pos_y       = PY_W'(py);
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // accept side and result check, both on pre-edge values
    always @(posedge aclk) begin
        placement_t got;
        placement_t want;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got = placement_t'(m_tdata[$bits(placement_t)-1:0]);
            if (placements_due.size() == 0) begin
                report_mismatch("unexpected result word", got, 0);
            end else begin
                want = placements_due.pop_front();
                if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
                if (got.new_sheet !== want.new_sheet)
                    report_mismatch("new_sheet", got.new_sheet, want.new_sheet);
                if (got.sheet_index !== want.sheet_index)
                    report_mismatch("sheet_index", got.sheet_index, want.sheet_index);
                if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
            end
        end
        if (aresetn && s_tvalid && s_tready)
            placements_due.push_back(place_rect(s_tdata[12:0], s_tdata[25:13]));
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: bursts of stall, none in quiet mode
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 17);
            end else begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 17);
            end
            repeat (n - 1) begin
                @(negedge aclk);
                if (quiet) break;
            end
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_rect(int unsigned rw, int unsigned rh);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, 13'(rh), 13'(rw)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (placements_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(int idx, int unsigned value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= CFG_DATA_W'(value);
        if (idx == CFG_W_IDX) pred_width = value & 32'h1FF;
        else pred_height = value & 32'h1FFF;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_directed_default;
        send_rect(0, 0);        // first request opens a sheet even when empty
        send_rect(0, 5);        // zero width on an open sheet
        send_rect(256, 1);
        send_rect(257, 1);      // too wide
        send_rect(1, 257);      // too tall
        send_rect(4096, 4096);
        send_rect(3000, 1);
        send_rect(1536, 2);
        send_rect(256, 255);    // fills the open sheet up to its top
    endtask

    task automatic test_directed_small;
        write_reg(CFG_W_IDX, 8);
        write_reg(CFG_H_IDX, 16);
        send_rect(3, 4);
        send_rect(5, 2);
        send_rect(2, 10);
        send_rect(8, 2);
        send_rect(1, 16);       // no room left, new sheet
        send_rect(7, 0);        // zero height fits beside the tall column
        send_rect(8, 0);        // zero height with no window
        send_rect(0, 16);
        send_rect(9, 1);
        write_reg(CFG_H_IDX, 3);  // sheet height lowered to 3
        send_rect(1, 1);
        send_rect(1, 3);
    endtask

    task automatic test_random(int n, int unsigned max_w, int unsigned max_h);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_rect($urandom_range(0, 4096), $urandom_range(0, 4096));
            else
                send_rect($urandom_range(0, max_w), $urandom_range(0, max_h));
        end
    endtask

    task automatic test_wide_sheet;
        write_reg(CFG_W_IDX, 511);   // clamps to full width
        write_reg(CFG_H_IDX, 8191);  // clamps to 4096
        repeat (18) begin
            if ($urandom_range(0, 5) == 0)
                send_rect($urandom_range(250, 256), $urandom_range(0, 4096));
            else
                send_rect($urandom_range(0, 4), $urandom_range(0, 4096));
        end
        send_rect(2, 4096);
    endtask

    task automatic test_clamped_low;
        write_reg(CFG_W_IDX, 0);
        write_reg(CFG_H_IDX, 0);
        test_random(10, 2, 2);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_default();
        test_directed_small();
        write_reg(CFG_W_IDX, 16);
        write_reg(CFG_H_IDX, 32);
        test_random(40, 17, 34);
        test_wide_sheet();
        test_clamped_low();
        write_reg(CFG_W_IDX, 1);
        write_reg(CFG_H_IDX, 4096);
        test_random(6, 1, 1200);
        write_reg(CFG_W_IDX, 5);
        write_reg(CFG_H_IDX, 9);
        quiet = 1'b1;
        test_random(15, 6, 10);
        drain();
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
